// File: rtl/rbs_pkg.sv
package rbs_pkg;

    // Unit direction components carry this many fraction bits (Q1.30)
    localparam int DIR_FRAC = 30;

    // Root unit: one result bit per stage for a 64-bit radicand
    localparam int SQRT_STEPS = 32;

    // Slab distance clamp, also the starting exit distance
    localparam logic signed [63:0] T_INF = 64'sh4000_0000_0000_0000;

    // Entry distance clamp used for the hit point product
    localparam logic [33:0] ENTRY_CAP = 34'h3_FFFF_FFFF;

    // Largest reportable entry distance
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // Parallel threshold after reset
    localparam logic [30:0] EPS_RESET = 31'd1074;

    // Per-axis ray data carried through the front end
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] lo;
        logic [30:0]      edge_len;
        logic [2:0]       dn;
    } t_front;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic               par;
        logic               pmiss;
        logic               dn;
        logic [30:0]        dm;
        logic [31:0]        org;
        logic signed [63:0] t_near;
        logic signed [63:0] t_far;
    } t_lane_res;

endpackage

// File: rtl/rbs_div.sv
module rbs_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    // Restoring long division, one quotient bit per stage. The numerator
    // shifts out of the top of r_nq while quotient bits shift in below.
    logic              r_v    [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    genvar s;
    generate
        for (s = 0; s < NUM_W; s++) begin : g_stage
            logic              v_in;
            logic [DEN_W-1:0]  rem_in;
            logic [DEN_W-1:0]  den_in;
            logic [NUM_W-1:0]  nq_in;
            logic [SIDE_W-1:0] side_in;
            logic [DEN_W:0]    trial;
            logic              ge;

            if (s == 0) begin : g_first
                assign v_in    = i_valid;
                assign rem_in  = '0;
                assign den_in  = i_den;
                assign nq_in   = i_num;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_v[s-1];
                assign rem_in  = r_rem[s-1];
                assign den_in  = r_den[s-1];
                assign nq_in   = r_nq[s-1];
                assign side_in = r_side[s-1];
            end

            // trial subtract of the divisor from the partial remainder
            assign trial = {rem_in, nq_in[NUM_W-1]};
            assign ge    = trial >= {1'b0, den_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                    r_nq[s]   <= {nq_in[NUM_W-2:0], ge};
                    r_den[s]  <= den_in;
                    r_side[s] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// File: rtl/rbs_sqrt.sv
module rbs_sqrt import rbs_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_n,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);

    // Digit-by-digit integer root, one result bit per stage
    logic              r_v    [SQRT_STEPS];
    logic [63:0]       r_n    [SQRT_STEPS];
    logic [63:0]       r_r    [SQRT_STEPS];
    logic [SIDE_W-1:0] r_side [SQRT_STEPS];

    genvar s;
    generate
        for (s = 0; s < SQRT_STEPS; s++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
            logic              v_in;
            logic [63:0]       n_in;
            logic [63:0]       r_in;
            logic [SIDE_W-1:0] side_in;
            logic [63:0]       rb;
            logic              ge;

            if (s == 0) begin : g_first
                assign v_in    = i_valid;
                assign n_in    = i_n;
                assign r_in    = '0;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_v[s-1];
                assign n_in    = r_n[s-1];
                assign r_in    = r_r[s-1];
                assign side_in = r_side[s-1];
            end

            assign rb = r_in + BIT;
            assign ge = n_in >= rb;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[s]    <= ge ? n_in - rb : n_in;
                    r_r[s]    <= ge ? (r_in >> 1) + BIT : r_in >> 1;
                    r_side[s] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_r[SQRT_STEPS-1][31:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

// File: rtl/rbs_lane.sv
module rbs_lane import rbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_zero,
    input  logic [30:0] i_eps,
    input  logic [30:0] i_mag,
    input  logic [31:0] i_len,
    input  logic [31:0] i_org,
    input  logic [31:0] i_lo,
    input  logic [30:0] i_edge,
    input  logic        i_dn,
    output t_lane_res   o_res
);

    localparam int S1_W = 97;
    localparam int S2_W = 68;

    // Normalize: dm = round(m * 2^30 / len)
    logic             r0_v;
    logic [61:0]      r0_num;
    logic [31:0]      r0_den;
    logic [S1_W-1:0]  r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_num  <= {1'b0, i_mag, 30'b0} + {31'b0, i_len[31:1]};
            r0_den  <= i_len;
            r0_side <= {i_zero, i_dn, i_edge, i_lo, i_org};
        end
    end

    logic            d1_v;
    logic [61:0]     d1_quo;
    logic [S1_W-1:0] d1_side;

    rbs_div #(.NUM_W(62), .DEN_W(32), .SIDE_W(S1_W)) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r0_v),
        .i_num   (r0_num),
        .i_den   (r0_den),
        .i_side  (r0_side),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Slab setup: plane offsets, parallel check
    logic [31:0]        s1_org;
    logic [31:0]        s1_lo;
    logic [30:0]        s1_edge;
    logic               s1_dn;
    logic               s1_zero;
    logic [30:0]        s1_dm;
    logic signed [33:0] s1_hi;
    logic signed [33:0] s1_org34;
    logic signed [33:0] s1_lo34;
    logic signed [33:0] s1_d1;
    logic signed [33:0] s1_d2;
    logic [33:0]        s1_m1;
    logic [33:0]        s1_m2;

    assign {s1_zero, s1_dn, s1_edge, s1_lo, s1_org} = d1_side;
    assign s1_dm    = d1_quo[30:0];
    assign s1_org34 = {{2{s1_org[31]}}, s1_org};
    assign s1_lo34  = {{2{s1_lo[31]}}, s1_lo};
    assign s1_hi    = s1_lo34 + $signed({3'b0, s1_edge});
    assign s1_d1    = s1_lo34 - s1_org34;
    assign s1_d2    = s1_hi - s1_org34;
    assign s1_m1    = s1_d1[33] ? 34'(-s1_d1) : s1_d1;
    assign s1_m2    = s1_d2[33] ? 34'(-s1_d2) : s1_d2;

    logic            r1_v;
    logic [63:0]     r1_n1;
    logic [63:0]     r1_n2;
    logic [30:0]     r1_dm;
    logic [S2_W-1:0] r1_side;
    logic            r1_neg2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n1   <= {s1_m1, 30'b0};
            r1_n2   <= {s1_m2, 30'b0};
            r1_dm   <= s1_dm;
            r1_neg2 <= s1_d2[33] ^ s1_dn;
            r1_side <= {s1_zero, s1_dn, s1_d1[33] ^ s1_dn,
                        (s1_dm == 31'd0) || (s1_dm < i_eps),
                        (s1_org34 < s1_lo34) || (s1_org34 > s1_hi),
                        s1_dm, s1_org};
        end
    end

    // Low and high plane distances
    logic            da_v;
    logic [63:0]     da_quo;
    logic [S2_W-1:0] da_side;
    logic            db_v;
    logic [63:0]     db_quo;
    logic            db_side;

    rbs_div #(.NUM_W(64), .DEN_W(31), .SIDE_W(S2_W)) u_lo_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r1_v),
        .i_num   (r1_n1),
        .i_den   (r1_dm),
        .i_side  (r1_side),
        .o_valid (da_v),
        .o_quo   (da_quo),
        .o_side  (da_side)
    );

    rbs_div #(.NUM_W(64), .DEN_W(31), .SIDE_W(1)) u_hi_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r1_v),
        .i_num   (r1_n2),
        .i_den   (r1_dm),
        .i_side  (r1_neg2),
        .o_valid (db_v),
        .o_quo   (db_quo),
        .o_side  (db_side)
    );

    // Clamp, sign and order the two distances
    logic               s2_zero;
    logic               s2_dn;
    logic               s2_neg1;
    logic               s2_par;
    logic               s2_pmiss;
    logic [30:0]        s2_dm;
    logic [31:0]        s2_org;
    logic [63:0]        s2_q1;
    logic [63:0]        s2_q2;
    logic signed [63:0] s2_t1;
    logic signed [63:0] s2_t2;

    assign {s2_zero, s2_dn, s2_neg1, s2_par, s2_pmiss, s2_dm, s2_org} = da_side;
    assign s2_q1 = (da_quo > 64'(T_INF)) ? 64'(T_INF) : da_quo;
    assign s2_q2 = (db_quo > 64'(T_INF)) ? 64'(T_INF) : db_quo;
    assign s2_t1 = s2_neg1 ? -$signed(s2_q1) : $signed(s2_q1);
    assign s2_t2 = db_side ? -$signed(s2_q2) : $signed(s2_q2);

    t_lane_res r2_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_res.valid <= 1'b0;
        end else if (i_en) begin
            r2_res.valid  <= da_v & db_v;
            r2_res.zero   <= s2_zero;
            r2_res.par    <= s2_par;
            r2_res.pmiss  <= s2_pmiss;
            r2_res.dn     <= s2_dn;
            r2_res.dm     <= s2_dm;
            r2_res.org    <= s2_org;
            r2_res.t_near <= (s2_t1 > s2_t2) ? s2_t2 : s2_t1;
            r2_res.t_far  <= (s2_t1 > s2_t2) ? s2_t1 : s2_t2;
        end
    end

    assign o_res = r2_res;

endmodule

// File: rtl/rbs_merge.sv
module rbs_merge import rbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_lane_res        i_lane [3],
    output logic             o_valid,
    output logic             o_hit,
    output logic [30:0]      o_entry,
    output logic [2:0][31:0] o_pt
);

    // Stage 1: entry is the max of zero and the near distances, exit the min of far ones
    logic signed [63:0] c_nr [3];
    logic signed [63:0] c_fr [3];
    logic signed [63:0] c_n01;
    logic signed [63:0] c_n2;
    logic signed [63:0] c_f01;
    logic [2:0]         c_pm;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_nr[a] = i_lane[a].par ? 64'sd0 : i_lane[a].t_near;
            c_fr[a] = i_lane[a].par ? T_INF : i_lane[a].t_far;
            c_pm[a] = i_lane[a].par & i_lane[a].pmiss;
        end
        c_n01 = (c_nr[0] > c_nr[1]) ? c_nr[0] : c_nr[1];
        c_n2  = (c_nr[2] > 64'sd0) ? c_nr[2] : 64'sd0;
        c_f01 = (c_fr[0] < c_fr[1]) ? c_fr[0] : c_fr[1];
    end

    logic               r1_v;
    logic               r1_ok;
    logic signed [63:0] r1_entry;
    logic signed [63:0] r1_exit;
    logic [2:0][30:0]   r1_dm;
    logic [2:0]         r1_dn;
    logic [2:0][31:0]   r1_org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_lane[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok    <= !i_lane[0].zero && (c_pm == 3'b000);
            r1_entry <= (c_n01 > c_n2) ? c_n01 : c_n2;
            r1_exit  <= (c_f01 < c_fr[2]) ? c_f01 : c_fr[2];
            for (int a = 0; a < 3; a++) begin
                r1_dm[a]  <= i_lane[a].dm;
                r1_dn[a]  <= i_lane[a].dn;
                r1_org[a] <= i_lane[a].org;
            end
        end
    end

    // Stage 2: hit decision and distance clamps
    logic             r2_v;
    logic             r2_hit;
    logic [30:0]      r2_dist;
    logic [33:0]      r2_e;
    logic [2:0][30:0] r2_dm;
    logic [2:0]       r2_dn;
    logic [2:0][31:0] r2_org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hit  <= r1_ok && (r1_entry <= r1_exit);
            r2_dist <= (r1_entry > $signed({33'b0, DIST_MAX})) ? DIST_MAX : r1_entry[30:0];
            r2_e    <= (r1_entry > $signed({30'b0, ENTRY_CAP})) ? ENTRY_CAP : r1_entry[33:0];
            r2_dm   <= r1_dm;
            r2_dn   <= r1_dn;
            r2_org  <= r1_org;
        end
    end

    // Stage 3: dir * entry as two partial products per axis
    logic             r3_v;
    logic             r3_hit;
    logic [30:0]      r3_dist;
    logic [2:0][47:0] r3_pl;
    logic [2:0][47:0] r3_ph;
    logic [2:0]       r3_dn;
    logic [2:0][31:0] r3_org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_hit  <= r2_hit;
            r3_dist <= r2_dist;
            r3_dn   <= r2_dn;
            r3_org  <= r2_org;
            for (int a = 0; a < 3; a++) begin
                r3_pl[a] <= {17'b0, r2_dm[a]} * {31'b0, r2_e[16:0]};
                r3_ph[a] <= {17'b0, r2_dm[a]} * {31'b0, r2_e[33:17]};
            end
        end
    end

    // Stage 4: sum partials, round half up from 30 fraction bits
    logic [2:0][64:0] c_p;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_p[a] = {17'b0, r3_pl[a]} + {r3_ph[a], 17'b0} + (65'd1 << (DIR_FRAC - 1));
        end
    end

    logic             r4_v;
    logic             r4_hit;
    logic [30:0]      r4_dist;
    logic [2:0][34:0] r4_off;
    logic [2:0]       r4_dn;
    logic [2:0][31:0] r4_org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_hit  <= r3_hit;
            r4_dist <= r3_dist;
            r4_dn   <= r3_dn;
            r4_org  <= r3_org;
            for (int a = 0; a < 3; a++) begin
                r4_off[a] <= c_p[a][64:DIR_FRAC];
            end
        end
    end

    // Stage 5: point = origin +/- offset, saturated; zeros on a miss
    logic signed [35:0] c_c  [3];
    logic [2:0][31:0]   c_pt;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_c[a] = r4_dn[a]
                   ? $signed({{4{r4_org[a][31]}}, r4_org[a]}) - $signed({1'b0, r4_off[a]})
                   : $signed({{4{r4_org[a][31]}}, r4_org[a]}) + $signed({1'b0, r4_off[a]});
            if (c_c[a] > 36'sh0_7FFF_FFFF) begin
                c_pt[a] = 32'h7FFF_FFFF;
            end else if (c_c[a] < -36'sh0_8000_0000) begin
                c_pt[a] = 32'h8000_0000;
            end else begin
                c_pt[a] = c_c[a][31:0];
            end
        end
    end

    logic             r5_v;
    logic             r5_hit;
    logic [30:0]      r5_dist;
    logic [2:0][31:0] r5_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_hit  <= r4_hit;
            r5_dist <= r4_hit ? r4_dist : 31'd0;
            r5_pt   <= r4_hit ? c_pt : '0;
        end
    end

    assign o_valid = r5_v;
    assign o_hit   = r5_hit;
    assign o_entry = r5_dist;
    assign o_pt    = r5_pt;

endmodule

// File: rtl/ray_box_slab_intersect_top.sv
// Depth: an accepted request reaches m_axis_tvalid mostly through the
//   32-stage root pipeline and the 62- and 64-stage divider pipelines per lane.
// Throughput: one request per cycle unless the two-entry output stage is full.
// Reset (i_rst_n, synchronous, active low) clears all valid flags and sets the
//   parallel threshold to 1074.
module ray_box_slab_intersect_top import rbs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write: parallel_epsilon
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data,
    // origin_x, origin_y, origin_z, target_x, target_y, target_z,
    // box_min_x, box_min_y, box_min_z, box_edge, zero pad
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [319:0] s_axis_tdata,
    // entry_distance, hit_x, hit_y, hit_z, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,
    // hit
    output logic         m_axis_tuser
);

    localparam int SQ_SIDE_W = $bits(t_front) + 1 + 93;

    // Position of the leading one, as the left shift that brings it to bit 30
    function automatic logic [4:0] f_up(input logic [30:0] v);
        logic [4:0] u;
        u = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                u = 5'(30 - i);
            end
        end
        return u;
    endfunction

    logic        w_en;
    logic        r_skid_v;
    logic [30:0] r_eps;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // Stage A: direction and its magnitudes
    t_front           c_fa;
    logic [2:0][31:0] c_tgt;
    logic [2:0][32:0] c_d;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_fa.org[a] = s_axis_tdata[32*a +: 32];
            c_tgt[a]    = s_axis_tdata[96 + 32*a +: 32];
            c_fa.lo[a]  = s_axis_tdata[192 + 32*a +: 32];
            c_d[a]      = {c_tgt[a][31], c_tgt[a]} - {c_fa.org[a][31], c_fa.org[a]};
            c_fa.dn[a]  = c_d[a][32];
        end
        c_fa.edge_len = s_axis_tdata[318:288];
    end

    logic             r_va;
    t_front           r_fa;
    logic [2:0][31:0] r_ma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa <= c_fa;
            for (int a = 0; a < 3; a++) begin
                r_ma[a] <= c_d[a][32] ? 32'(-c_d[a]) : c_d[a][31:0];
            end
        end
    end

    // Stage B: largest magnitude and common shift
    logic [31:0] c_m01;
    logic [31:0] c_big;

    assign c_m01 = (r_ma[0] > r_ma[1]) ? r_ma[0] : r_ma[1];
    assign c_big = (c_m01 > r_ma[2]) ? c_m01 : r_ma[2];

    logic             r_vb;
    t_front           r_fb;
    logic [2:0][31:0] r_mb;
    logic             r_zb;
    logic             r_down;
    logic [4:0]       r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fb   <= r_fa;
            r_mb   <= r_ma;
            r_zb   <= c_big == 32'd0;
            r_down <= c_big[31];
            r_up   <= c_big[31] ? 5'd0 : f_up(c_big[30:0]);
        end
    end

    // Stage C: scale all components by the common shift
    logic             r_vc;
    t_front           r_fc;
    logic [2:0][30:0] r_mc;
    logic             r_zc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fc <= r_fb;
            r_zc <= r_zb;
            for (int a = 0; a < 3; a++) begin
                r_mc[a] <= r_down ? r_mb[a][31:1] : 31'(r_mb[a] << r_up);
            end
        end
    end

    // Stage D: squares
    logic             r_vd;
    t_front           r_fd;
    logic [2:0][30:0] r_md;
    logic             r_zd;
    logic [2:0][61:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (w_en) begin
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd <= r_fc;
            r_md <= r_mc;
            r_zd <= r_zc;
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= {31'b0, r_mc[a]} * {31'b0, r_mc[a]};
            end
        end
    end

    // Stage E: sum of squares
    logic                 r_ve;
    logic [SQ_SIDE_W-1:0] r_se;
    logic [63:0]          r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_en) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_se  <= {r_zd, r_md, r_fd};
            r_sum <= {2'b0, r_sq[0]} + {2'b0, r_sq[1]} + {2'b0, r_sq[2]};
        end
    end

    // Vector length
    logic                 w_sq_v;
    logic [31:0]          w_len;
    logic [SQ_SIDE_W-1:0] w_sq_side;
    t_front               w_f;
    logic [2:0][30:0]     w_m;
    logic                 w_zero;

    rbs_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ve),
        .i_n     (r_sum),
        .i_side  (r_se),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    assign {w_zero, w_m, w_f} = w_sq_side;

    // One lane per axis
    t_lane_res w_lane [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            rbs_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_sq_v),
                .i_zero  (w_zero),
                .i_eps   (r_eps),
                .i_mag   (w_m[g]),
                .i_len   (w_len),
                .i_org   (w_f.org[g]),
                .i_lo    (w_f.lo[g]),
                .i_edge  (w_f.edge_len),
                .i_dn    (w_f.dn[g]),
                .o_res   (w_lane[g])
            );
        end
    endgenerate

    logic             w_pv;
    logic             w_hit;
    logic [30:0]      w_entry;
    logic [2:0][31:0] w_pt;

    rbs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_lane  (w_lane),
        .o_valid (w_pv),
        .o_hit   (w_hit),
        .o_entry (w_entry),
        .o_pt    (w_pt)
    );

    // Output register plus skid entry
    logic [127:0] c_pdata;
    logic         c_take;
    logic         r_out_v;
    logic [127:0] r_out_d;
    logic         r_out_u;
    logic [127:0] r_skid_d;
    logic         r_skid_u;

    assign c_pdata = {1'b0, w_pt[2], w_pt[1], w_pt[0], w_entry};
    assign c_take  = r_out_v & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (c_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_pv) begin
            if (!r_out_v || c_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (c_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (c_take) begin
                r_out_d <= r_skid_d;
                r_out_u <= r_skid_u;
            end
        end else if (w_pv) begin
            if (!r_out_v || c_take) begin
                r_out_d <= c_pdata;
                r_out_u <= w_hit;
            end else begin
                r_skid_d <= c_pdata;
                r_skid_u <= w_hit;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tuser  = r_out_u;

endmodule

// File: tb/ray_box_slab_intersect_top_test.sv
`timescale 1ns / 100ps

module ray_box_slab_intersect_top_test;

    localparam int  DIR_FRAC_BITS = 30;
    localparam int  IDLE_WAIT     = 220;     // longer than the request-to-result latency
    localparam int  STALL_LIMIT   = 20000;
    localparam int  PHASE_ITEMS   = 310;
    localparam longint T_CLAMP    = 64'sh4000_0000_0000_0000;
    localparam longint unsigned HIT_E_CAP = (64'd1 << 34) - 1;
    localparam bit [30:0] EPS_DEFAULT = 31'd1074;

    // one box test request
    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] tgt [3];
        logic signed [31:0] lo  [3];
        logic [30:0]        edge_len;
    } t_ray_req;

    // one box test answer
    typedef struct packed {
        logic               hit;
        logic [30:0]        entry_dist;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_box_hit;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [30:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;

    ray_box_slab_intersect_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_ray_req  ray_queue [$];
    t_box_hit  hit_queue [$];
    bit [30:0] cur_eps;
    int        mismatch_cnt;
    int        burst_left;
    int        gap_left;
    int        stall_cycles;
    longint unsigned cyc;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint slab_dist(longint diff, longint unsigned dmag, bit dneg);
        longint unsigned q;
        longint unsigned dabs;
        dabs = (diff < 0) ? longint'(-diff) : longint'(diff);
        q = (dabs << DIR_FRAC_BITS) / dmag;
        if (q > longint'(T_CLAMP)) q = T_CLAMP;
        return ((diff < 0) != dneg) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // slab test of one ray against the cube
    function automatic t_box_hit cube_hit(t_ray_req rq, bit [30:0] eps);
        longint org [3];
        longint lo [3];
        longint unsigned m [3];
        longint unsigned dm [3];
        bit dn [3];
        longint d, hi, t1, t2, sw, entry, exitd, off;
        longint unsigned big, sum, len, e, p;
        int up, down;
        t_box_hit r;
        r = '0;
        big = 0;
        sum = 0;
        up = 0;
        down = 0;
        entry = 0;
        exitd = T_CLAMP;
        for (int a = 0; a < 3; a++) begin
            org[a] = rq.org[a];
            lo[a]  = rq.lo[a];
            d      = longint'(rq.tgt[a]) - org[a];
            dn[a]  = d < 0;
            m[a]   = (d < 0) ? -d : d;
            if (m[a] > big) big = m[a];
        end
        if (big == 0) return r;
        while (big >= (64'd1 << 31)) begin big >>= 1; down++; end
        while (big < (64'd1 << 30)) begin big <<= 1; up++; end
        for (int a = 0; a < 3; a++) begin
            m[a] = (m[a] >> down) << up;
            sum += m[a] * m[a];
        end
        len = root_floor(sum);
        for (int a = 0; a < 3; a++)
            dm[a] = ((m[a] << DIR_FRAC_BITS) + (len >> 1)) / len;
        for (int a = 0; a < 3; a++) begin
            hi = lo[a] + longint'(rq.edge_len);
            if (dm[a] == 0 || dm[a] < eps) begin
                if (org[a] < lo[a] || org[a] > hi) return r;
            end else begin
                t1 = slab_dist(lo[a] - org[a], dm[a], dn[a]);
                t2 = slab_dist(hi - org[a], dm[a], dn[a]);
                if (t1 > t2) begin sw = t1; t1 = t2; t2 = sw; end
                if (t1 > entry) entry = t1;
                if (t2 < exitd) exitd = t2;
                if (entry > exitd) return r;
            end
        end
        r.hit        = 1'b1;
        r.entry_dist = (entry > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : entry[30:0];
        e = (entry > longint'(HIT_E_CAP)) ? HIT_E_CAP : entry;
        for (int a = 0; a < 3; a++) begin
            p   = dm[a] * e;
            off = (p + (64'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS;
            case (a)
                0: r.px = clip32(dn[a] ? org[a] - off : org[a] + off);
                1: r.py = clip32(dn[a] ? org[a] - off : org[a] + off);
                default: r.pz = clip32(dn[a] ? org[a] - off : org[a] + off);
            endcase
        end
        return r;
    endfunction

    function automatic logic [319:0] pack_ray(t_ray_req rq);
        logic [319:0] v;
        v = '0;
        for (int a = 0; a < 3; a++) begin
            v[32*a +: 32]       = rq.org[a];
            v[96 + 32*a +: 32]  = rq.tgt[a];
            v[192 + 32*a +: 32] = rq.lo[a];
        end
        v[288 +: 31] = rq.edge_len;
        return v;
    endfunction

    // append one request to the pending queue
    task automatic add_ray(t_ray_req rq);
        ray_queue = {ray_queue, rq};
    endtask

    // request driver: bursts with random gaps, data held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                hit_queue = {hit_queue, cube_hit(ray_queue[0], cur_eps)};
                ray_queue.pop_front();
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the current request
            end else if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (ray_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_ray(ray_queue[0]);
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin
        t_box_hit got;
        t_box_hit exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            cyc           <= 0;
        end else begin
            cyc <= cyc + 1;
            case (cyc[10:9])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= ($urandom_range(0, 2) == 0);
                default: m_axis_tready <= (cyc[4:2] != 3'd5);
            endcase
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit        = m_axis_tuser;
                got.entry_dist = m_axis_tdata[30:0];
                got.px         = m_axis_tdata[62:31];
                got.py         = m_axis_tdata[94:63];
                got.pz         = m_axis_tdata[126:95];
                if (hit_queue.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: hit=%0d dist=%h", got.hit,
                                 got.entry_dist);
                end else begin
                    exp_r = hit_queue.pop_front();
                    if (got !== exp_r) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: hit %0d/%0d dist %h/%h x %h/%h y %h/%h",
                                      " z %h/%h (expected/actual)"},
                                     exp_r.hit, got.hit, exp_r.entry_dist, got.entry_dist,
                                     exp_r.px, got.px, exp_r.py, got.py,
                                     exp_r.pz, got.pz);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ray_box_slab_intersect_top regression: fail");
                $finish;
            end
        end
    end

    function automatic t_ray_req mk_ray(int ox, int oy, int oz, int tx, int ty, int tz,
                                        int bx, int by, int bz, bit [30:0] ed);
        t_ray_req rq;
        rq.org[0] = ox; rq.org[1] = oy; rq.org[2] = oz;
        rq.tgt[0] = tx; rq.tgt[1] = ty; rq.tgt[2] = tz;
        rq.lo[0]  = bx; rq.lo[1]  = by; rq.lo[2]  = bz;
        rq.edge_len = ed;
        return rq;
    endfunction

    // random request: mostly rays aimed at or near a modest cube
    function automatic t_ray_req rand_ray();
        t_ray_req rq;
        int sel;
        int span;
        sel = $urandom_range(0, 99);
        rq.edge_len = 31'($urandom_range(1, 1 << 22));
        span = (sel < 30) ? (1 << 20) : (1 << 27);
        for (int a = 0; a < 3; a++) begin
            rq.lo[a]  = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            rq.org[a] = rq.lo[a] + int'($urandom_range(0, 2 * span)) - span;
            if (sel < 60)
                rq.tgt[a] = rq.lo[a] + int'($urandom_range(0, rq.edge_len));
            else
                rq.tgt[a] = rq.lo[a] + int'($urandom_range(0, 2 * span)) - span;
        end
        if (sel >= 60 && sel < 70) begin
            // axis nearly or exactly parallel
            sel = $urandom_range(0, 2);
            rq.tgt[sel] = rq.org[sel] + int'($urandom_range(0, 8)) - 4;
        end else if (sel >= 70 && sel < 90) begin
            for (int a = 0; a < 3; a++) begin
                rq.org[a] = $urandom;
                rq.tgt[a] = $urandom;
                rq.lo[a]  = $urandom;
            end
            rq.edge_len = 31'($urandom);
        end else if (sel >= 90 && sel < 94) begin
            rq.tgt = rq.org;
        end
        return rq;
    endfunction

    task automatic wait_drained();
        while (ray_queue.size() != 0 || hit_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_eps(bit [30:0] val);
        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_eps = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            add_ray(rand_ray());
            // one mid-phase pause until everything has drained
            if (i == n / 2) wait_drained();
        end
    endtask

    // stimulus
    initial begin
        bit [30:0] eps_list [5];
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        cur_eps      = EPS_DEFAULT;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero length, straight hits, parallel misses, grazing corner
        add_ray(mk_ray(5, 6, 7, 5, 6, 7, 0, 0, 0, 100));
        add_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_ray(mk_ray(-65536, 32768, 32768, 0, 32768, 32768, 0, 0, 0, 65536));
        add_ray(mk_ray(-65536, 32768, 32768, -131072, 32768, 32768, 0, 0, 0, 65536));
        add_ray(mk_ray(-65536, 131072, 32768, 0, 131072, 32768, 0, 0, 0, 65536));
        add_ray(mk_ray(-65536, 32768, -5, 0, 32768, -5, 0, 0, 0, 65536));
        add_ray(mk_ray(-65536, -65536, 0, 0, 0, 0, 0, 0, 0, 65536));
        add_ray(mk_ray(-65536, 0, 0, 0, 65536, 0, 0, 65536, 0, 65536));
        add_ray(mk_ray(-65536, 65536, 0, 0, 65537, 0, 0, 0, 0, 65536));
        add_ray(mk_ray(100, 100, 100, 200, 300, 400, 0, 0, 0, 65536));
        add_ray(mk_ray(65536, 65536, 65536, 0, 0, 0, 0, 0, 0, 65536));
        add_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7000_0000, 32'h7000_0000, 32'h7000_0000, 31'h100_0000));
        add_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
        add_ray(mk_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                       32'h7FFF_0000, -100, -100, 31'h7FFF_FFFF));
        add_ray(mk_ray(0, 0, 0, 1, 1 << 30, 0, 0, -10, -10, 31'h7FFF_FFFF));
        add_ray(mk_ray(0, 0, 0, 1 << 30, 1 << 30, 1 << 30,
                       32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0));
        add_ray(mk_ray(0, 0, 0, -1, -1, -1, -65536, -65536, -65536, 65536));
        add_ray(mk_ray(1 << 20, 0, 0, 0, 0, 0, -(1 << 20), -(1 << 20),
                       -(1 << 20), 31'h7FFF_FFFF));
        add_ray(mk_ray(0, 0, 0, 1 << 30, 900, 0, 1000, -10, -10, 100));
        add_ray(mk_ray(0, 0, 0, 1 << 30, 2000, 0, 1000, 3000, -10, 100));
        run_random(PHASE_ITEMS);

        // threshold settings: zero, widest, middle values, back to default
        eps_list[0] = 31'd0;
        eps_list[1] = 31'h4000_0000;
        eps_list[2] = 31'd1 << 20;
        eps_list[3] = 31'($urandom_range(0, 1 << 30));
        eps_list[4] = EPS_DEFAULT;
        for (int ph = 0; ph < 5; ph++) begin
            write_eps(eps_list[ph]);
            add_ray(mk_ray(-65536, 32768, 32768, 0, 32768 + ph, 32768, 0, 0, 0, 65536));
            run_random(ph == 4 ? 100 : PHASE_ITEMS - 40);
        end

        wait_drained();
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0 && hit_queue.size() == 0)
            $display("ray_box_slab_intersect_top regression: pass");
        else
            $display("ray_box_slab_intersect_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/rbs_pkg.sv
rtl/rbs_div.sv
rtl/rbs_sqrt.sv
rtl/rbs_lane.sv
rtl/rbs_merge.sv
rtl/ray_box_slab_intersect_top.sv
tb/ray_box_slab_intersect_top_test.sv
